@@ rtl/core/sra_pkg.sv @@
// shared types and constants for the sequence range allocator
// depends on nothing; imported by sra_cell, sequence_range_allocator and tb
package sra_pkg;

    localparam int unsigned VAL_W  = 64;
    localparam int unsigned SIZE_W = 32;
    localparam int unsigned CIDX_W = 2;

    localparam logic [VAL_W-1:0] POOL_START_RESET = 64'd10000;
    localparam logic [VAL_W-1:0] POOL_END_RESET   = 64'hffff_ffff_ffff_ffff;

    localparam logic [CIDX_W-1:0] CFG_POOL_START = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_POOL_END   = 2'd1;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RESOLVE
    } t_state;

    // broadcast from the controller to every slot of the list
    typedef struct packed {
        logic              eval;
        logic              commit;
        logic              is_rel;
        logic [SIZE_W-1:0] size;
        logic [VAL_W-1:0]  rel_low;
        logic [VAL_W-1:0]  rel_high;
    } t_cell_ctl;

endpackage

@@ rtl/core/sra_cell.sv @@
// one slot of the returned-range list: holds a range, tests it for an exact fit
// and shifts toward the head when it or an earlier slot is taken; depends on sra_pkg
module sra_cell
    import sra_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic             i_prev_hit,
    output logic             o_hit,
    input  logic             i_prev_valid,
    input  logic             i_next_valid,
    input  logic [VAL_W-1:0] i_next_low,
    input  logic [VAL_W-1:0] i_next_high,
    input  logic [VAL_W-1:0] i_grant_low,
    input  logic [VAL_W-1:0] i_grant_high,
    output logic [VAL_W-1:0] o_grant_low,
    output logic [VAL_W-1:0] o_grant_high,
    output logic             o_valid,
    output logic [VAL_W-1:0] o_low,
    output logic [VAL_W-1:0] o_high
);

    logic             r_valid, n_valid;
    logic             r_match, n_match;
    logic [VAL_W-1:0] r_low, n_low;
    logic [VAL_W-1:0] r_high, n_high;
    logic             w_sel;
    logic             w_load;

    // first matching slot is the one with no match below it
    assign o_hit  = i_prev_hit | r_match;
    assign w_sel  = r_match & ~i_prev_hit;
    assign w_load = ~r_valid & i_prev_valid;

    assign o_grant_low  = i_grant_low  | (w_sel ? r_low  : '0);
    assign o_grant_high = i_grant_high | (w_sel ? r_high : '0);

    assign o_valid = r_valid;
    assign o_low   = r_low;
    assign o_high  = r_high;

    always_comb begin
        n_valid = r_valid;
        n_match = r_match;
        n_low   = r_low;
        n_high  = r_high;
        if (i_ctl.eval) begin
            n_match = r_valid && ((r_high - r_low) == {{(VAL_W-SIZE_W){1'b0}}, i_ctl.size});
        end
        if (i_ctl.commit) begin
            n_match = 1'b0;
            if (i_ctl.is_rel) begin
                if (w_load) begin
                    n_valid = 1'b1;
                    n_low   = i_ctl.rel_low;
                    n_high  = i_ctl.rel_high;
                end
            end else if (o_hit) begin
                // close the gap left by the taken entry
                n_valid = i_next_valid;
                n_low   = i_next_low;
                n_high  = i_next_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_match <= n_match;
        end
        r_low  <= n_low;
        r_high <= n_high;
    end

endmodule

@@ rtl/core/sequence_range_allocator.sv @@
// sequence range allocator: exact-fit list of returned ranges plus bump pointer
// result registered at commit in the resolve state, held while the output stalls
// next request waits for the last to commit (slot compare, then resolve and shift)
// no clearing pass; reset empties the list, next_free = 10000, pool_end = all ones
// depends on sra_pkg and sra_cell
module sequence_range_allocator
    import sra_pkg::*;
#(
    parameter int unsigned FREE_ENTRIES = 16
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_req_type,
    input  logic [SIZE_W-1:0] i_alloc_size,
    input  logic [VAL_W-1:0]  i_release_low,
    input  logic [VAL_W-1:0]  i_release_high,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [VAL_W-1:0]  o_grant_low,
    output logic [VAL_W-1:0]  o_grant_high,
    output logic              o_granted,
    output logic              o_from_recycled,
    output logic              o_list_full,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [VAL_W-1:0]  i_cfg_data
);

    t_state r_state, n_state;

    logic              r_req_type;
    logic [SIZE_W-1:0] r_size;
    logic [VAL_W-1:0]  r_rel_low;
    logic [VAL_W-1:0]  r_rel_high;
    logic [VAL_W-1:0]  r_next_free;
    logic [VAL_W-1:0]  r_pool_end;
    logic [VAL_W:0]    r_sum;

    logic              r_out_valid;
    logic [VAL_W-1:0]  r_grant_low, n_grant_low;
    logic [VAL_W-1:0]  r_grant_high, n_grant_high;
    logic              r_granted, n_granted;
    logic              r_recycled, n_recycled;
    logic              r_full, n_full;

    logic              w_accept;
    logic              w_commit;
    logic              w_fits;
    t_cell_ctl         w_ctl;

    logic [FREE_ENTRIES:0]     w_hit;
    logic [VAL_W-1:0]          w_glow  [FREE_ENTRIES+1];
    logic [VAL_W-1:0]          w_ghigh [FREE_ENTRIES+1];
    logic [FREE_ENTRIES-1:0]   w_valid;
    logic [VAL_W-1:0]          w_low   [FREE_ENTRIES];
    logic [VAL_W-1:0]          w_high  [FREE_ENTRIES];

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_valid) n_state = ST_EVAL;
            ST_EVAL:    n_state = ST_RESOLVE;
            ST_RESOLVE: if (w_commit) n_state = (i_valid ? ST_EVAL : ST_IDLE);
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_commit = 1'b0;
        o_stall  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
            end
            ST_EVAL: begin
                o_stall = 1'b1;
            end
            ST_RESOLVE: begin
                w_commit = ~r_out_valid | ~i_stall;
                o_stall  = ~w_commit;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    assign w_accept    = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;

    assign w_ctl.eval     = (r_state == ST_EVAL);
    assign w_ctl.commit   = w_commit;
    assign w_ctl.is_rel   = (r_req_type == REQ_RELEASE);
    assign w_ctl.size     = r_size;
    assign w_ctl.rel_low  = r_rel_low;
    assign w_ctl.rel_high = r_rel_high;

    // ---------------- slot chain ----------------
    assign w_hit[0]   = 1'b0;
    assign w_glow[0]  = '0;
    assign w_ghigh[0] = '0;

    for (genvar k = 0; k < FREE_ENTRIES; k++) begin : g_slot
        logic             w_pv;
        logic             w_nv;
        logic [VAL_W-1:0] w_nl;
        logic [VAL_W-1:0] w_nh;

        if (k == 0) begin : g_head
            assign w_pv = 1'b1;
        end else begin : g_body
            assign w_pv = w_valid[k-1];
        end

        if (k == FREE_ENTRIES - 1) begin : g_tail
            assign w_nv = 1'b0;
            assign w_nl = '0;
            assign w_nh = '0;
        end else begin : g_inner
            assign w_nv = w_valid[k+1];
            assign w_nl = w_low[k+1];
            assign w_nh = w_high[k+1];
        end

        sra_cell u_slot (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_hit   (w_hit[k]),
            .o_hit        (w_hit[k+1]),
            .i_prev_valid (w_pv),
            .i_next_valid (w_nv),
            .i_next_low   (w_nl),
            .i_next_high  (w_nh),
            .i_grant_low  (w_glow[k]),
            .i_grant_high (w_ghigh[k]),
            .o_grant_low  (w_glow[k+1]),
            .o_grant_high (w_ghigh[k+1]),
            .o_valid      (w_valid[k]),
            .o_low        (w_low[k]),
            .o_high       (w_high[k])
        );
    end

    // ---------------- result ----------------
    // bump sum carries its 65th bit so a wrap never fits
    assign w_fits = ~r_sum[VAL_W] & (r_sum[VAL_W-1:0] < r_pool_end);

    always_comb begin
        n_grant_low  = '0;
        n_grant_high = '0;
        n_granted    = 1'b0;
        n_recycled   = 1'b0;
        n_full       = 1'b0;
        if (r_req_type == REQ_RELEASE) begin
            n_full = w_valid[FREE_ENTRIES-1];
        end else if (w_hit[FREE_ENTRIES]) begin
            n_grant_low  = w_glow[FREE_ENTRIES];
            n_grant_high = w_ghigh[FREE_ENTRIES];
            n_granted    = (r_size != '0);
            n_recycled   = 1'b1;
        end else if (w_fits) begin
            n_grant_low  = r_next_free;
            n_grant_high = r_sum[VAL_W-1:0];
            n_granted    = (r_size != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_next_free <= POOL_START_RESET;
            r_pool_end  <= POOL_END_RESET;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_commit && r_req_type == REQ_ALLOC && !w_hit[FREE_ENTRIES] && w_fits) begin
                r_next_free <= r_sum[VAL_W-1:0];
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POOL_START: r_next_free <= i_cfg_data;
                    CFG_POOL_END:   r_pool_end  <= i_cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type <= i_req_type;
            r_size     <= i_alloc_size;
            r_rel_low  <= i_release_low;
            r_rel_high <= i_release_high;
        end
        if (r_state == ST_EVAL) begin
            r_sum <= {1'b0, r_next_free} + {{(VAL_W+1-SIZE_W){1'b0}}, r_size};
        end
        if (w_commit) begin
            r_grant_low  <= n_grant_low;
            r_grant_high <= n_grant_high;
            r_granted    <= n_granted;
            r_recycled   <= n_recycled;
            r_full       <= n_full;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_grant_low     = r_grant_low;
    assign o_grant_high    = r_grant_high;
    assign o_granted       = r_granted;
    assign o_from_recycled = r_recycled;
    assign o_list_full     = r_full;

    // ---------------- checks ----------------
    a_eval_then_resolve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |=> (r_state == ST_RESOLVE))
        else $error("compare cycle not followed by resolve");

    a_list_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((w_valid + 1'b1) & w_valid) == '0))
        else $error("occupied slots not packed at the head");

    a_full_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_list_full) |-> (!o_granted && !o_from_recycled))
        else $error("dropped release reported a grant");

    a_grant_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_granted) |-> (o_grant_high != o_grant_low))
        else $error("grant flagged on an empty range");

    a_single_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_req_type == REQ_RELEASE) |-> !$past(r_state == ST_IDLE))
        else $error("release committed without a compare cycle");

endmodule

@@ bench/tb.sv @@
// self-checking bench for sequence_range_allocator: directed table, then random phases
// predicts every grant and release result in a local model of the free list and bump pointer
// depends on sra_pkg and the sequence_range_allocator rtl
module tb
    import sra_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FREE_ENTRIES  = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 65;

    localparam logic [CIDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [VAL_W-1:0]  ALL_ONES    = '1;

    typedef struct packed {
        logic [VAL_W-1:0] low;
        logic [VAL_W-1:0] high;
        logic             granted;
        logic             recycled;
        logic             full;
    } t_grant;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] size;
        logic [VAL_W-1:0]  rel_low;
        logic [VAL_W-1:0]  rel_high;
        logic              fixed;
        t_grant            res;
    } t_req;

    localparam t_grant NONE = '{64'd0, 64'd0, 1'b0, 1'b0, 1'b0};
    localparam int NUM_DIRECTED = 18;

    // rows with fixed set carry a hand-written result, the rest go to the predictor
    localparam t_req DIRECTED [NUM_DIRECTED] = '{
        '{REQ_ALLOC,   32'd0,   64'd0, 64'd0, 1'b1, '{64'd10000, 64'd10000, 1'b0, 1'b0, 1'b0}},
        '{REQ_ALLOC,   32'd5,   64'd0, 64'd0, 1'b1, '{64'd10000, 64'd10005, 1'b1, 1'b0, 1'b0}},
        '{REQ_ALLOC,   '1,      64'd0, 64'd0, 1'b1,
          '{64'd10005, 64'd4294977300, 1'b1, 1'b0, 1'b0}},
        '{REQ_RELEASE, 32'd0,   64'd100, 64'd100, 1'b1, NONE},
        '{REQ_RELEASE, 32'd0,   64'd0, ALL_ONES, 1'b1, NONE},
        '{REQ_RELEASE, 32'd0,   64'd50, 64'd20, 1'b1, NONE},
        '{REQ_RELEASE, 32'd0,   64'd1000, 64'd1007, 1'b1, NONE},
        '{REQ_RELEASE, 32'd0,   64'd2000, 64'd2007, 1'b1, NONE},
        '{REQ_ALLOC,   32'd0,   64'd0, 64'd0, 1'b1, '{64'd100, 64'd100, 1'b0, 1'b1, 1'b0}},
        '{REQ_ALLOC,   32'd7,   64'd0, 64'd0, 1'b1, '{64'd1000, 64'd1007, 1'b1, 1'b1, 1'b0}},
        '{REQ_ALLOC,   32'd7,   64'd0, 64'd0, 1'b1, '{64'd2000, 64'd2007, 1'b1, 1'b1, 1'b0}},
        '{REQ_RELEASE, 32'd0,   ALL_ONES, ALL_ONES, 1'b1, NONE},
        '{REQ_ALLOC,   32'd0,   64'd0, 64'd0, 1'b1, '{ALL_ONES, ALL_ONES, 1'b0, 1'b1, 1'b0}},
        // reversed entry whose wrapped length is 32
        '{REQ_RELEASE, 32'd0,   64'hffff_ffff_ffff_fff0, 64'h10, 1'b1, NONE},
        '{REQ_ALLOC,   32'd32,  64'd0, 64'd0, 1'b1,
          '{64'hffff_ffff_ffff_fff0, 64'h10, 1'b1, 1'b1, 1'b0}},
        '{REQ_ALLOC,   32'd3,   64'd0, 64'd0, 1'b0, NONE},
        '{REQ_RELEASE, 32'd0,   64'h5a5a_a5a5_5a5a_a5a5, 64'h5a5a_a5a5_5a5a_a5a8, 1'b0, NONE},
        '{REQ_ALLOC,   32'd3,   64'd0, 64'd0, 1'b0, NONE}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_req_type = REQ_ALLOC;
    logic [SIZE_W-1:0] i_alloc_size = '0;
    logic [VAL_W-1:0]  i_release_low = '0;
    logic [VAL_W-1:0]  i_release_high = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [VAL_W-1:0]  o_grant_low;
    logic [VAL_W-1:0]  o_grant_high;
    logic              o_granted;
    logic              o_from_recycled;
    logic              o_list_full;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [VAL_W-1:0]  i_cfg_data = '0;

    sequence_range_allocator #(.FREE_ENTRIES(FREE_ENTRIES)) u_top (.*);

    always #2 i_clk = ~i_clk;

    // local copy of the allocator state
    logic [VAL_W-1:0] free_lo_m [FREE_ENTRIES];
    logic [VAL_W-1:0] free_hi_m [FREE_ENTRIES];
    int               free_cnt_m = 0;
    logic [VAL_W-1:0] next_free_m = POOL_START_RESET;
    logic [VAL_W-1:0] pool_end_m = POOL_END_RESET;

    t_req   req_q [$];
    t_grant grant_q [$];
    t_req   cur_req;
    t_grant tx_pred;
    int     errors = 0;
    int     cycle_cnt = 0;
    int     send_idle_pct = 7;
    int     recv_idle_pct = 51;

    function automatic t_grant predict_grant(input t_req rq);
        t_grant         r;
        logic [VAL_W:0] sum;
        int             hit;
        r = NONE;
        hit = -1;
        if (rq.req_type == REQ_ALLOC) begin
            for (int i = 0; i < free_cnt_m; i++)
                if (hit < 0 && free_hi_m[i] - free_lo_m[i] == {32'd0, rq.size})
                    hit = i;
            if (hit >= 0) begin
                r.low      = free_lo_m[hit];
                r.high     = free_hi_m[hit];
                r.recycled = 1'b1;
                r.granted  = (rq.size != 0);
                for (int k = hit; k < free_cnt_m - 1; k++) begin
                    free_lo_m[k] = free_lo_m[k+1];
                    free_hi_m[k] = free_hi_m[k+1];
                end
                free_cnt_m--;
            end else begin
                // 65-bit sum so a carry never fits
                sum = {1'b0, next_free_m} + {33'd0, rq.size};
                if (!sum[VAL_W] && sum[VAL_W-1:0] < pool_end_m) begin
                    r.low       = next_free_m;
                    r.high      = sum[VAL_W-1:0];
                    r.granted   = (rq.size != 0);
                    next_free_m = sum[VAL_W-1:0];
                end
            end
        end else if (free_cnt_m < FREE_ENTRIES) begin
            free_lo_m[free_cnt_m] = rq.rel_low;
            free_hi_m[free_cnt_m] = rq.rel_high;
            free_cnt_m++;
        end else begin
            r.full = 1'b1;
        end
        return r;
    endfunction

    function automatic t_req rand_req(input int rel_pct);
        t_req rq;
        rq = '0;
        rq.req_type = ($urandom_range(99) < rel_pct) ? REQ_RELEASE : REQ_ALLOC;
        case ($urandom_range(7))
            0, 1, 2, 3: rq.size = $urandom_range(7);
            4: rq.size = $urandom_range(255);
            5: rq.size = $urandom;
            6: rq.size = '1;
            default: rq.size = '0;
        endcase
        rq.rel_low = {$urandom, $urandom};
        case ($urandom_range(7))
            0: rq.rel_high = {$urandom, $urandom};
            1: begin
                // high may wrap below low
                rq.rel_low  = ALL_ONES - $urandom_range(3);
                rq.rel_high = rq.rel_low + $urandom_range(7);
            end
            2: rq.rel_high = rq.rel_low + {32'd0, rq.size};
            default: rq.rel_high = rq.rel_low + $urandom_range(7);
        endcase
        return rq;
    endfunction

    function automatic void check_field(input string name, input logic [VAL_W-1:0] exp_v,
                                        input logic [VAL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                // the model always advances, typed rows only replace the expected result
                tx_pred = predict_grant(cur_req);
                grant_q.insert(grant_q.size(), cur_req.fixed ? cur_req.res : tx_pred);
            end
            if (!i_valid || !o_stall) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req = req_q.pop_front();
                    i_valid        <= 1'b1;
                    i_req_type     <= cur_req.req_type;
                    i_alloc_size   <= cur_req.size;
                    i_release_low  <= cur_req.rel_low;
                    i_release_high <= cur_req.rel_high;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result side, with a long hold-off twice in the run
    int     rx_count = 0;
    int     hold_left = 0;
    t_grant rx_exp;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual low %h high %h",
                             $time, o_grant_low, o_grant_high);
                    errors++;
                end else begin
                    rx_exp = grant_q.pop_front();
                    check_field("grant_low", rx_exp.low, o_grant_low);
                    check_field("grant_high", rx_exp.high, o_grant_high);
                    check_field("granted", 64'(rx_exp.granted), 64'(o_granted));
                    check_field("from_recycled", 64'(rx_exp.recycled), 64'(o_from_recycled));
                    check_field("list_full", 64'(rx_exp.full), 64'(o_list_full));
                end
                rx_count++;
                if (rx_count == 100 || rx_count == 300)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_POOL_START: begin
                next_free_m = data;
            end
            CFG_POOL_END: pool_end_m = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        do @(posedge i_clk); while (req_q.size() != 0 || i_valid || grant_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random(input int n);
        int rel_pct;
        rel_pct = 50;
        for (int k = 0; k < n; k++) begin
            // bursts lean to releases, to allocations or to neither so the list fills and drains
            if (k % 16 == 0)
                case ($urandom_range(2))
                    0: rel_pct = 15;
                    1: rel_pct = 50;
                    default: rel_pct = 85;
                endcase
            req_q.insert(req_q.size(), rand_req(rel_pct));
        end
    endtask

    task automatic run_phase(input logic [VAL_W-1:0] start_v, input logic [VAL_W-1:0] end_v,
                             input int s_pct, input int r_pct);
        settle();
        write_reg(CFG_POOL_END, end_v);
        write_reg(CFG_POOL_START, start_v);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        queue_random(PHASE_ITEMS);
    endtask

    initial begin
        logic [VAL_W-1:0] base;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[n])
            req_q.insert(req_q.size(), DIRECTED[n]);
        queue_random(PHASE_ITEMS);

        settle();
        write_reg(CFG_SPARE_A, {$urandom, $urandom});
        run_phase(64'hffff_ffff_0000_0000, ALL_ONES, 7, 51);
        run_phase(ALL_ONES, 64'd0, 51, 7);
        settle();
        write_reg(CFG_SPARE_B, {$urandom, $urandom});
        run_phase(64'd1000, 64'd1000 + $urandom_range(64, 4096), 51, 7);
        run_phase(64'd0, ALL_ONES, 0, 0);
        base = {1'b0, $urandom, 16'($urandom_range(65535, 0)), 15'd0};
        run_phase(base, base + {$urandom, $urandom}, 0, 0);

        settle();
        if (grant_q.size() != 0) begin
            $display("%0t: %0d results never arrived, expected 0 actual %0d",
                     $time, grant_q.size(), grant_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/sra_pkg.sv
rtl/core/sra_cell.sv
rtl/core/sequence_range_allocator.sv
bench/tb.sv
